// ===== src/dsat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsat_pkg
// Shared types, constants, and the sign-extension and clamp-step functions of
// the motor output desaturator.
// ----------------------------------------------------------------------------
package dsat_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int IN_W        = 16;
  localparam int VAL_W       = 20;
  localparam int LIMIT_W     = 12;

  localparam logic [LIMIT_W-1:0] UPPER_RESET = 12'd2000;
  localparam logic [LIMIT_W-1:0] LOWER_RESET = 12'd100;

  // register indexes of the configuration port
  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  typedef logic signed [IN_W-1:0]    in_val_t;
  typedef logic signed [VAL_W-1:0]   mval_t;
  typedef mval_t [MOTOR_COUNT-1:0]   motors_t;
  typedef logic [LIMIT_W-1:0]        limit_t;

  typedef struct packed {
    logic       upper;  // 1: clamp from above, 0: clamp from below
    logic [1:0] motor;
  } step_t;

  typedef struct packed {
    limit_t upper;
    limit_t lower;
  } limits_t;

  localparam step_t STEP_U1 = '{upper: 1'b1, motor: 2'd0};
  localparam step_t STEP_U2 = '{upper: 1'b1, motor: 2'd1};
  localparam step_t STEP_U3 = '{upper: 1'b1, motor: 2'd2};
  localparam step_t STEP_U4 = '{upper: 1'b1, motor: 2'd3};
  localparam step_t STEP_L1 = '{upper: 1'b0, motor: 2'd0};
  localparam step_t STEP_L2 = '{upper: 1'b0, motor: 2'd1};
  localparam step_t STEP_L3 = '{upper: 1'b0, motor: 2'd2};
  localparam step_t STEP_L4 = '{upper: 1'b0, motor: 2'd3};

  function automatic mval_t sext_in(input in_val_t v);
    return mval_t'({{(VAL_W-IN_W){v[IN_W-1]}}, v});
  endfunction

  // One clamp step. In both directions the others move by (limit - value).
  function automatic motors_t clamp_step(input motors_t m, input step_t s,
                                         input limit_t lim);
    mval_t   lim_s;
    mval_t   cur;
    mval_t   d;
    logic    hit;
    motors_t r;
    lim_s = mval_t'({{(VAL_W-LIMIT_W){1'b0}}, lim});
    cur   = m[s.motor];
    d     = lim_s - cur;
    hit   = s.upper ? (cur > lim_s) : (cur < lim_s);
    r     = m;
    if (hit) begin
      for (int j = 0; j < MOTOR_COUNT; j++) begin
        if (j == int'(s.motor)) begin
          r[j] = lim_s;
        end else begin
          r[j] = m[j] + d;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/dsat_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsat_cfg
// Limit registers of the desaturator, written through a plain write port.
// ----------------------------------------------------------------------------
module dsat_cfg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   write_en,
  input  wire logic                   write_index,
  input  wire dsat_pkg::limit_t       write_data,
  output dsat_pkg::limits_t           limits
);
  import dsat_pkg::*;

  limits_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.upper <= UPPER_RESET;
      regs.lower <= LOWER_RESET;
    end else if (write_en) begin
      unique case (write_index)
        REG_UPPER: regs.upper <= write_data;
        REG_LOWER: regs.lower <= write_data;
        default:   regs       <= regs;
      endcase
    end
  end

  assign limits = regs;

  a_reset_values: assert property (@(posedge clk)
    rst |=> (regs.upper == UPPER_RESET) && (regs.lower == LOWER_RESET))
    else $error("limit registers not at reset values");

  a_upper_write: assert property (@(posedge clk) disable iff (rst)
    write_en && (write_index == REG_UPPER) |=> regs.upper == $past(write_data))
    else $error("upper limit write lost");

  a_no_write_hold: assert property (@(posedge clk) disable iff (rst)
    !write_en |=> $stable(regs))
    else $error("limit registers changed without a write");

endmodule
`default_nettype wire

// ===== src/dsat_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsat_stage
// One pipeline stage: two consecutive clamp steps followed by a register,
// with valid/stall flow control.
// ----------------------------------------------------------------------------
module dsat_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dsat_pkg::step_t     step_a,
  input  wire dsat_pkg::step_t     step_b,
  input  wire dsat_pkg::limits_t   limits,
  input  wire logic                up_valid,
  output logic                     up_stall,
  input  wire dsat_pkg::motors_t   up_motors,
  output logic                     down_valid,
  input  wire logic                down_stall,
  output dsat_pkg::motors_t        down_motors
);
  import dsat_pkg::*;

  logic    valid;
  motors_t motors;
  motors_t mid;
  motors_t motors_next;
  limit_t  lim_a;
  limit_t  lim_b;
  logic    load;

  assign lim_a = step_a.upper ? limits.upper : limits.lower;
  assign lim_b = step_b.upper ? limits.upper : limits.lower;

  always_comb begin
    mid         = clamp_step(up_motors, step_a, lim_a);
    motors_next = clamp_step(mid, step_b, lim_b);
  end

  // take a new beat when the register is empty or being drained
  assign load     = !valid || !down_stall;
  assign up_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      motors <= motors_next;
    end
  end

  assign down_valid  = valid;
  assign down_motors = motors;

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("stage holds a beat after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    valid && down_stall |=> valid && $stable(motors))
    else $error("stalled beat changed or dropped");

  a_fill_when_empty: assert property (@(posedge clk) disable iff (rst)
    up_valid && !valid |=> valid)
    else $error("beat offered to an empty stage was not taken");

endmodule
`default_nettype wire

// ===== src/motor_output_desaturator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motor_output_desaturator
// Air-mode style desaturation of four quadcopter motor commands.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with motor_1_in..motor_4_in (16-bit
// signed). Output channel: out_valid / out_stall with motor_1_out..
// motor_4_out (20-bit signed). A beat moves when valid is high and stall low.
// The limits are set through write_en / write_index / write_data (index 0:
// upper limit, index 1: lower limit); write them only while the block is
// empty.
// Four upper clamps run first, then four lower clamps, two per stage, so the
// pipeline has four register stages, which a beat passes through in order.
// One beat enters per cycle while in_stall is low; the stage count of the
// clamp chain sets the latency.
// Reset empties every stage and loads upper limit 2000, lower limit 100.
// While out_stall is high the output beat holds; stages behind it keep
// filling, and in_stall rises once all four stages hold a beat.
// ----------------------------------------------------------------------------
module motor_output_desaturator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              write_en,
  input  wire logic              write_index,
  input  wire dsat_pkg::limit_t  write_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dsat_pkg::in_val_t motor_1_in,
  input  wire dsat_pkg::in_val_t motor_2_in,
  input  wire dsat_pkg::in_val_t motor_3_in,
  input  wire dsat_pkg::in_val_t motor_4_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dsat_pkg::mval_t        motor_1_out,
  output dsat_pkg::mval_t        motor_2_out,
  output dsat_pkg::mval_t        motor_3_out,
  output dsat_pkg::mval_t        motor_4_out
);
  import dsat_pkg::*;

  localparam int STAGES = 4;

  limits_t limits;
  motors_t in_motors;
  logic    valid_s [STAGES+1];
  logic    stall_s [STAGES+1];
  motors_t motors_s [STAGES+1];

  localparam step_t STEP_A [STAGES] = '{STEP_U1, STEP_U3, STEP_L1, STEP_L3};
  localparam step_t STEP_B [STAGES] = '{STEP_U2, STEP_U4, STEP_L2, STEP_L4};

  dsat_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .limits      (limits)
  );

  assign in_motors[0] = sext_in(motor_1_in);
  assign in_motors[1] = sext_in(motor_2_in);
  assign in_motors[2] = sext_in(motor_3_in);
  assign in_motors[3] = sext_in(motor_4_in);

  assign valid_s[0]  = in_valid;
  assign motors_s[0] = in_motors;
  assign in_stall    = stall_s[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    dsat_stage u_stage (
      .clk         (clk),
      .rst         (rst),
      .step_a      (STEP_A[k]),
      .step_b      (STEP_B[k]),
      .limits      (limits),
      .up_valid    (valid_s[k]),
      .up_stall    (stall_s[k]),
      .up_motors   (motors_s[k]),
      .down_valid  (valid_s[k+1]),
      .down_stall  (stall_s[k+1]),
      .down_motors (motors_s[k+1])
    );
  end

  assign stall_s[STAGES] = out_stall;
  assign out_valid       = valid_s[STAGES];
  assign motor_1_out     = motors_s[STAGES][0];
  assign motor_2_out     = motors_s[STAGES][1];
  assign motor_3_out     = motors_s[STAGES][2];
  assign motor_4_out     = motors_s[STAGES][3];

endmodule
`default_nettype wire
